@@ sv/leib_pkg.sv @@
package leib_pkg;

   // command codes of an input beat
   typedef enum logic {
      CMD_KEY  = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_ECHO    = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_REFUSED = 2'd3
   } kind_type;

   localparam logic [7:0] KEY_BACKSPACE = 8'd8;
   localparam logic [7:0] KEY_LF        = 8'd10;
   localparam logic [7:0] KEY_CR        = 8'd13;
   localparam logic [7:0] KEY_SPACE     = 8'd32;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] key_byte;
   } req_item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } rsp_item_type;

endpackage

@@ sv/leib_ram.sv @@
module leib_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/line_edit_input_buffer.sv @@
// Canonical-mode line editor over a circular byte queue held in a single
// RAM of QUEUE_DEPTH bytes. A beat is taken at a clock edge where start is
// high and busy is low; every beat except a backspace that erases a byte
// leaves busy low, so beats may follow each other on every clock. An erasing
// backspace gives three echo beats (backspace, space, backspace) back to
// back and holds busy high while the space and the second backspace are
// produced. The first result of a beat passes through the pending register,
// aligned with the queue RAM's registered read port, and then the result
// register before it leaves on rsp_strobe. Results are shown for one
// cycle only and cannot be held off, so the receiver must take every
// strobe. A backspace on an empty line gives no result at all.
// The queue RAM is not cleared after reset; only written bytes are read.
module line_edit_input_buffer
   import leib_pkg::*;
#(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] FULL_C   = CNT_W'(QUEUE_DEPTH - 1);

   // queue pointers and phase
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             released_ff, released_in;

   // remaining echo beats of an erasing backspace
   logic [1:0]       bs_left_ff, bs_left_in;

   // pending result, aligned with the ram read data
   logic             p_valid_ff, p_valid_in;
   kind_type         p_kind_ff, p_kind_in;
   logic [7:0]       p_data_ff, p_data_in;
   logic             p_last_ff, p_last_in;
   logic             p_deliver_ff, p_deliver_in;

   // result register
   logic             rsp_strobe_ff;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   // ram ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [7:0]       rd_data;

   logic             accept;
   logic [CNT_W-1:0] count;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] tail_next;
   logic [IDX_W-1:0] tail_prev;

   assign accept = start && !busy;
   assign busy   = (bs_left_ff != 2'd0);

   // wrap-around neighbours of the pointers
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   // bytes held while editing
   always_comb begin
      if (tail_ff >= head_ff) begin
         count = {1'b0, tail_ff} - {1'b0, head_ff};
      end else begin
         count = {1'b0, tail_ff} + DEPTH_C - {1'b0, head_ff};
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      released_in  = released_ff;
      bs_left_in   = bs_left_ff;
      p_valid_in   = 1'b0;
      p_kind_in    = KIND_ECHO;
      p_data_in    = 8'd0;
      p_last_in    = 1'b1;
      p_deliver_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = req_item.key_byte;
      rd_en        = 1'b0;

      if (busy) begin
         // rest of the backspace, space, backspace echo
         p_valid_in = 1'b1;
         p_kind_in  = KIND_ECHO;
         p_data_in  = (bs_left_ff == 2'd2) ? KEY_SPACE : KEY_BACKSPACE;
         p_last_in  = (bs_left_ff == 2'd1);
         bs_left_in = bs_left_ff - 2'd1;
      end else if (accept) begin
         if (req_item.cmd == CMD_READ) begin
            p_valid_in = 1'b1;
            if (released_ff) begin
               // hand out the oldest byte, editing resumes once drained
               rd_en        = 1'b1;
               p_kind_in    = KIND_DELIVER;
               p_deliver_in = 1'b1;
               head_in      = head_next;
               if (head_next == tail_ff) begin
                  released_in = 1'b0;
               end
            end else begin
               p_kind_in = KIND_EMPTY;
            end
         end else if (released_ff) begin
            p_valid_in = 1'b1;
            p_kind_in  = KIND_REFUSED;
         end else if (req_item.key_byte == KEY_BACKSPACE) begin
            if (count != '0) begin
               p_valid_in = 1'b1;
               p_data_in  = KEY_BACKSPACE;
               p_last_in  = 1'b0;
               bs_left_in = 2'd2;
               tail_in    = tail_prev;
            end
         end else if (req_item.key_byte == KEY_CR || req_item.key_byte == KEY_LF
                      || count == FULL_C) begin
            // end of line, or no room left: close the line with a newline
            p_valid_in  = 1'b1;
            p_data_in   = KEY_LF;
            wr_en       = 1'b1;
            wr_data     = KEY_LF;
            tail_in     = tail_next;
            released_in = 1'b1;
         end else begin
            p_valid_in = 1'b1;
            p_data_in  = req_item.key_byte;
            wr_en      = 1'b1;
            tail_in    = tail_next;
         end
      end
   end

   // delivered bytes come straight from the ram read port
   always_comb begin
      rsp_item_in.kind = p_kind_ff;
      rsp_item_in.data = p_deliver_ff ? rd_data : p_data_ff;
      rsp_item_in.last = p_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         released_ff   <= 1'b0;
         bs_left_ff    <= 2'd0;
         p_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         released_ff   <= released_in;
         bs_left_ff    <= bs_left_in;
         p_valid_ff    <= p_valid_in;
         rsp_strobe_ff <= p_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_kind_ff    <= p_kind_in;
      p_data_ff    <= p_data_in;
      p_last_ff    <= p_last_in;
      p_deliver_ff <= p_deliver_in;
      rsp_item_ff  <= rsp_item_in;
   end

   leib_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

@@ sv/leib_checker.sv @@
module leib_checker
   import leib_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_strobe,
   input rsp_item_type rsp_item
);

   // a beat that is not the last of its item is followed at once by another echo
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |=> rsp_strobe && rsp_item.kind == KIND_ECHO)
      else $error("echo burst broken");

   // a taken read is answered by one closing result, after the pending and result registers
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.cmd == CMD_READ |=> ##1 rsp_strobe && rsp_item.last)
      else $error("read beat not answered");

   // busy only follows a taken backspace
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_item.cmd == CMD_KEY
                            && req_item.key_byte == KEY_BACKSPACE))
      else $error("busy without backspace");

   // busy covers the two remaining echo beats
   a_busy_length: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |=> busy)
      else $error("busy too short");

endmodule

bind line_edit_input_buffer leib_checker u_leib_checker (.*);
